@@ sv/mpe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and tag constants of the MessagePack item encoder.
// No dependencies.
package mpe_pkg;

	typedef enum logic [3:0] {
		CMD_NIL      = 4'd0,
		CMD_TRUE     = 4'd1,
		CMD_FALSE    = 4'd2,
		CMD_SIGNED   = 4'd3,
		CMD_UNSIGNED = 4'd4,
		CMD_FLOAT32  = 4'd5,
		CMD_FLOAT64  = 4'd6,
		CMD_BLOB     = 4'd7,
		CMD_STRING   = 4'd8,
		CMD_ARRAY    = 4'd9,
		CMD_MAP      = 4'd10,
		CMD_EXT      = 4'd11
	} cmd_t;

	localparam logic [7:0] TAG_NIL      = 8'hc0;
	localparam logic [7:0] TAG_FALSE    = 8'hc2;
	localparam logic [7:0] TAG_TRUE     = 8'hc3;
	localparam logic [7:0] TAG_BIN8     = 8'hc4;
	localparam logic [7:0] TAG_BIN16    = 8'hc5;
	localparam logic [7:0] TAG_BIN32    = 8'hc6;
	localparam logic [7:0] TAG_EXT8     = 8'hc7;
	localparam logic [7:0] TAG_EXT16    = 8'hc8;
	localparam logic [7:0] TAG_EXT32    = 8'hc9;
	localparam logic [7:0] TAG_FLOAT32  = 8'hca;
	localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
	localparam logic [7:0] TAG_UINT8    = 8'hcc;
	localparam logic [7:0] TAG_UINT16   = 8'hcd;
	localparam logic [7:0] TAG_UINT32   = 8'hce;
	localparam logic [7:0] TAG_UINT64   = 8'hcf;
	localparam logic [7:0] TAG_INT8     = 8'hd0;
	localparam logic [7:0] TAG_INT16    = 8'hd1;
	localparam logic [7:0] TAG_INT32    = 8'hd2;
	localparam logic [7:0] TAG_INT64    = 8'hd3;
	localparam logic [7:0] TAG_FIXEXT1  = 8'hd4;
	localparam logic [7:0] TAG_FIXEXT2  = 8'hd5;
	localparam logic [7:0] TAG_FIXEXT4  = 8'hd6;
	localparam logic [7:0] TAG_FIXEXT8  = 8'hd7;
	localparam logic [7:0] TAG_FIXEXT16 = 8'hd8;
	localparam logic [7:0] TAG_STR8     = 8'hd9;
	localparam logic [7:0] TAG_STR16    = 8'hda;
	localparam logic [7:0] TAG_STR32    = 8'hdb;
	localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
	localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
	localparam logic [7:0] TAG_MAP16    = 8'hde;
	localparam logic [7:0] TAG_MAP32    = 8'hdf;
	localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
	localparam logic [7:0] TAG_FIXARRAY = 8'h90;
	localparam logic [7:0] TAG_FIXMAP   = 8'h80;

	typedef struct packed {
		logic [3:0]  command;
		logic [63:0] value;
		logic [7:0]  ext_type;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} out_t;

	// Byte sequence of one item, first byte in the top bits, cnt bytes valid.
	typedef struct packed {
		logic [71:0] seq;
		logic [3:0]  cnt;
		logic        err;
	} desc_t;

endpackage
`default_nettype wire

@@ sv/mpe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Front end: classifies an accepted command into a byte-sequence descriptor.
// Depends on mpe_pkg.
module mpe_front import mpe_pkg::*; (
	input  wire logic  take,
	input  wire in_t   item,
	output logic       push,
	output desc_t      desc
);

	logic [7:0]  tag;
	logic [63:0] pay;
	logic [3:0]  nb;
	logic        err;
	logic        known;
	logic [63:0] v;
	logic [63:0] aligned;

	assign v = item.value;

	always_comb begin
		tag   = TAG_NIL;
		pay   = '0;
		nb    = 4'd0;
		err   = 1'b0;
		known = 1'b1;
		case (item.command)
			CMD_NIL:   tag = TAG_NIL;
			CMD_TRUE:  tag = TAG_TRUE;
			CMD_FALSE: tag = TAG_FALSE;
			CMD_SIGNED, CMD_UNSIGNED: begin
				pay = v;
				if (item.command == CMD_SIGNED && v[63]) begin
					if (&v[63:5]) begin
						tag = v[7:0];
					end else if (&v[63:7]) begin
						tag = TAG_INT8;
						nb  = 4'd1;
					end else if (&v[63:15]) begin
						tag = TAG_INT16;
						nb  = 4'd2;
					end else if (&v[63:31]) begin
						tag = TAG_INT32;
						nb  = 4'd4;
					end else begin
						tag = TAG_INT64;
						nb  = 4'd8;
					end
				end else if (v[63:7] == '0) begin
					tag = v[7:0];
				end else if (v[63:8] == '0) begin
					tag = TAG_UINT8;
					nb  = 4'd1;
				end else if (v[63:16] == '0) begin
					tag = TAG_UINT16;
					nb  = 4'd2;
				end else if (v[63:32] == '0) begin
					tag = TAG_UINT32;
					nb  = 4'd4;
				end else begin
					tag = TAG_UINT64;
					nb  = 4'd8;
				end
			end
			CMD_FLOAT32: begin
				tag = TAG_FLOAT32;
				pay = {32'd0, v[31:0]};
				nb  = 4'd4;
			end
			CMD_FLOAT64: begin
				tag = TAG_FLOAT64;
				pay = v;
				nb  = 4'd8;
			end
			CMD_BLOB, CMD_STRING, CMD_ARRAY, CMD_MAP: begin
				pay = {32'd0, v[31:0]};
				if (v[63:32] != '0) begin
					tag = 8'h00;
					err = 1'b1;
				end else if (item.command == CMD_BLOB || item.command == CMD_STRING) begin
					if (v[31:5] == '0) begin
						tag = TAG_FIXSTR | {3'd0, v[4:0]};
					end else if (v[31:8] == '0) begin
						tag = (item.command == CMD_BLOB) ? TAG_BIN8 : TAG_STR8;
						nb  = 4'd1;
					end else if (v[31:16] == '0) begin
						tag = (item.command == CMD_BLOB) ? TAG_BIN16 : TAG_STR16;
						nb  = 4'd2;
					end else begin
						tag = (item.command == CMD_BLOB) ? TAG_BIN32 : TAG_STR32;
						nb  = 4'd4;
					end
				end else begin
					if (v[31:4] == '0) begin
						tag = ((item.command == CMD_ARRAY) ? TAG_FIXARRAY : TAG_FIXMAP)
							| {4'd0, v[3:0]};
					end else if (v[31:16] == '0) begin
						tag = (item.command == CMD_ARRAY) ? TAG_ARRAY16 : TAG_MAP16;
						nb  = 4'd2;
					end else begin
						tag = (item.command == CMD_ARRAY) ? TAG_ARRAY32 : TAG_MAP32;
						nb  = 4'd4;
					end
				end
			end
			CMD_EXT: begin
				// type byte rides as the last payload byte
				if (v == 64'd1) begin
					tag = TAG_FIXEXT1;
					pay = {56'd0, item.ext_type};
					nb  = 4'd1;
				end else if (v == 64'd2) begin
					tag = TAG_FIXEXT2;
					pay = {56'd0, item.ext_type};
					nb  = 4'd1;
				end else if (v == 64'd4) begin
					tag = TAG_FIXEXT4;
					pay = {56'd0, item.ext_type};
					nb  = 4'd1;
				end else if (v == 64'd8) begin
					tag = TAG_FIXEXT8;
					pay = {56'd0, item.ext_type};
					nb  = 4'd1;
				end else if (v == 64'd16) begin
					tag = TAG_FIXEXT16;
					pay = {56'd0, item.ext_type};
					nb  = 4'd1;
				end else if (v[63:8] == '0) begin
					tag = TAG_EXT8;
					pay = {48'd0, v[7:0], item.ext_type};
					nb  = 4'd2;
				end else if (v[63:16] == '0) begin
					tag = TAG_EXT16;
					pay = {40'd0, v[15:0], item.ext_type};
					nb  = 4'd3;
				end else begin
					tag = TAG_EXT32;
					pay = {24'd0, v[31:0], item.ext_type};
					nb  = 4'd5;
				end
			end
			default: known = 1'b0;
		endcase
	end

	always_comb begin
		case (nb)
			4'd1:    aligned = {pay[7:0],  56'd0};
			4'd2:    aligned = {pay[15:0], 48'd0};
			4'd3:    aligned = {pay[23:0], 40'd0};
			4'd4:    aligned = {pay[31:0], 32'd0};
			4'd5:    aligned = {pay[39:0], 24'd0};
			4'd8:    aligned = pay;
			default: aligned = '0;
		endcase
	end

	assign push      = take && known;
	assign desc.seq  = {tag, aligned};
	assign desc.cnt  = nb + 4'd1;
	assign desc.err  = err;

endmodule
`default_nettype wire

@@ sv/mpe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Two-entry descriptor queue between front and back end.
// Depends on mpe_pkg.
module mpe_queue import mpe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t wr_desc,
	input  wire logic  pop,
	output logic       full,
	output logic       not_empty,
	output desc_t      rd_desc
);

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign full      = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign rd_desc   = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

@@ sv/mpe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Back end: shifts the byte sequence of each descriptor out, one beat a cycle.
// Depends on mpe_pkg.
module mpe_back import mpe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire desc_t q_desc,
	output logic       pop,
	output logic       strobe,
	output out_t       result
);

	logic [71:0] seq_q;
	logic [3:0]  rem_q;
	logic        err_q;
	logic        act_q;

	assign pop = q_valid && (!act_q || rem_q == 4'd1);

	always_ff @(posedge clk) begin
		if (pop) begin
			seq_q <= q_desc.seq;
			err_q <= q_desc.err;
		end else begin
			seq_q <= {seq_q[63:0], 8'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			rem_q <= 4'd0;
		end else if (pop) begin
			act_q <= 1'b1;
			rem_q <= q_desc.cnt;
		end else if (act_q) begin
			act_q <= rem_q != 4'd1;
			rem_q <= rem_q - 4'd1;
		end
	end

	assign strobe          = act_q;
	assign result.out_byte = seq_q[71:64];
	assign result.last     = rem_q == 4'd1;
	assign result.error    = err_q;

endmodule
`default_nettype wire

@@ sv/msgpack_item_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// MessagePack item encoder, top level: front end, descriptor queue, back end.
// Depends on mpe_pkg, mpe_front, mpe_queue, mpe_back.
//
// A command is taken at a clock edge with start high and busy low. Its encoding
// leaves as one beat per cycle on result, marked by strobe, tag first, then the
// big-endian payload, with last on the final beat; an item's encoded length is
// 1 to 9 bytes, and the back end shifts out one byte a cycle. Beats of queued
// successive items follow with no gap. The receiver cannot stall:
// every strobed beat must be taken. A two-entry queue holds classified items,
// and busy is high only while it is full. A blob, string, array or map length
// of 2^32 or more gives one beat with error and last set and a zero byte.
// Unused command codes are taken and produce nothing.
module msgpack_item_encoder import mpe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire in_t  item,
	output logic      strobe,
	output out_t      result
);

	logic  push;
	logic  pop;
	logic  not_empty;
	desc_t wr_desc;
	desc_t rd_desc;

	mpe_front u_front (
		.take (start && !busy),
		.item (item),
		.push (push),
		.desc (wr_desc)
	);

	mpe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_desc   (wr_desc),
		.pop       (pop),
		.full      (busy),
		.not_empty (not_empty),
		.rd_desc   (rd_desc)
	);

	mpe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (not_empty),
		.q_desc  (rd_desc),
		.pop     (pop),
		.strobe  (strobe),
		.result  (result)
	);

endmodule
`default_nettype wire

@@ sv/mpe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for msgpack_item_encoder, with its bind.
// Depends on mpe_pkg.
module mpe_checker import mpe_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire in_t  item,
	input wire logic strobe,
	input wire out_t result
);

	// an item's beats are contiguous
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |=> strobe)
		else $error("gap inside an item");

	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.error |-> result.last && result.out_byte == 8'h00)
		else $error("bad error beat");

	// queue can only fill while the back end is draining
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe)
		else $error("busy with idle output");

	// idle encoder: queue write, then back end load, then the beat
	a_nil_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !strobe && !$past(start) && item.command == CMD_NIL
		|-> ##2 strobe && result.out_byte == TAG_NIL && result.last)
		else $error("nil not emitted");

endmodule

bind msgpack_item_encoder mpe_checker u_mpe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.strobe (strobe),
	.result (result)
);
`default_nettype wire
